FILE: src/sticky_least_loaded_router_top_defines.svh
// Assertion macros for the sticky least-loaded router.
// Included by the top level; depends on nothing else.
`ifndef STICKY_LEAST_LOADED_ROUTER_TOP_DEFINES_SVH
`define STICKY_LEAST_LOADED_ROUTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/slr_pkg.sv
// Types and constants shared by the sticky least-loaded router.
// Depends on nothing; imported by the top level.
package slr_pkg;

  localparam int unsigned ID_W    = 10;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SVC_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned NUM_SVC = 4;
  localparam int unsigned LOAD_W  = 11;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_CONNECT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNBOUND = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  conn_id;
  } slr_req_t;

  typedef struct packed {
    logic [SVC_W-1:0]  target_service;
    logic [STAT_W-1:0] status;
  } slr_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [SVC_W-1:0] svc;
  } slr_entry_t;

endpackage

FILE: src/sticky_least_loaded_router_top.sv
// Sticky least-loaded router: route table memory, per-service load counters and control.
// Depends on slr_pkg and sticky_least_loaded_router_top_defines.svh.
//
// Usage: a command beat is taken at a rising edge with start high and busy low.
// The req beat carries cmd (connect, data, close) and conn_id. In the next cycle the
// route table entry has been read; in that cycle the result is worked out, the entry
// and the service counters are updated as the command needs, and the result is registered.
// The rsp beat is shown in the following cycle with done high for that cycle only.
// busy is high for exactly one cycle after an accepted beat, so a new command is not
// taken while the previous one is in its lookup, which waits on the registered read
// of the route table memory. The next command can be accepted in the very cycle its
// predecessor's result is shown.
// The receiver cannot hold results off, so no result ever waits.
// After reset the block sweeps the route table, one entry a cycle, over all
// min(CONN_SLOTS, 1024) entries with busy high; the service counters clear at once.
// A conn_id at or beyond CONN_SLOTS is treated as unbound by every command.
module sticky_least_loaded_router_top #(
  parameter int unsigned CONN_SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  slr_pkg::slr_req_t req,
  output logic              done,
  output slr_pkg::slr_rsp_t rsp
);
  import slr_pkg::*;

  localparam int unsigned ID_SPAN = 1 << ID_W;
  localparam int unsigned DEPTH   = (CONN_SLOTS < ID_SPAN) ? CONN_SLOTS : ID_SPAN;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam logic [ID_W:0]   DEPTH_V = (ID_W + 1)'(DEPTH);
  localparam logic [AW-1:0]   LAST_A  = AW'(DEPTH - 1);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;

  slr_entry_t mem [DEPTH];
  slr_entry_t rdata;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [AW-1:0]     clr_addr;
  slr_req_t          req_q;
  logic [LOAD_W-1:0] load [NUM_SVC];

  logic              accept;
  logic              in_range;
  logic              bound;
  logic              we;
  logic [AW-1:0]     waddr;
  slr_entry_t        wdata;
  logic              inc_en;
  logic              dec_en;
  logic [SVC_W-1:0]  inc_svc;
  logic [SVC_W-1:0]  pick;
  logic              sel_a;
  logic              sel_b;
  logic              sel_top;
  logic [LOAD_W-1:0] min_a;
  logic [LOAD_W-1:0] min_b;
  slr_rsp_t          rsp_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      rdata <= mem[req.conn_id[AW-1:0]];
    end
  end

  // Pairwise least-loaded tree; a tie goes to the later index.
  always_comb begin
    sel_a   = !(load[0] < load[1]);
    sel_b   = !(load[2] < load[3]);
    min_a   = sel_a ? load[1] : load[0];
    min_b   = sel_b ? load[3] : load[2];
    sel_top = !(min_a < min_b);
    pick    = sel_top ? {1'b1, sel_b} : {1'b0, sel_a};
  end

  always_comb begin
    in_range   = ({1'b0, req_q.conn_id} < DEPTH_V);
    bound      = in_range && rdata.valid;
    we         = 1'b0;
    waddr      = req_q.conn_id[AW-1:0];
    wdata      = '0;
    inc_en     = 1'b0;
    dec_en     = 1'b0;
    inc_svc    = pick;
    rsp_next   = '{target_service: '0, status: ST_UNBOUND};
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == LAST_A) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_next = S_IDLE;
        if (in_range) begin
          unique case (req_q.cmd)
            CMD_CONNECT: begin
              if (bound) begin
                rsp_next = '{target_service: rdata.svc, status: ST_DUP};
              end else begin
                we       = 1'b1;
                wdata    = '{valid: 1'b1, svc: pick};
                inc_en   = 1'b1;
                rsp_next = '{target_service: pick, status: ST_OK};
              end
            end
            CMD_DATA: begin
              if (bound) begin
                rsp_next = '{target_service: rdata.svc, status: ST_OK};
              end
            end
            CMD_CLOSE: begin
              if (bound) begin
                we       = 1'b1;
                dec_en   = 1'b1;
                inc_svc  = rdata.svc;
                rsp_next = '{target_service: rdata.svc, status: ST_OK};
              end
            end
            default: begin
              rsp_next = '{target_service: '0, status: ST_UNBOUND};
            end
          endcase
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_LOOKUP);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (state == S_LOOKUP) begin
      rsp <= rsp_next;
    end
  end

  for (genvar i = 0; i < NUM_SVC; i++) begin : g_load
    always_ff @(posedge clk) begin
      if (rst) begin
        load[i] <= '0;
      end else if (inc_en && (pick == SVC_W'(i)) && (load[i] != LOAD_MAX)) begin
        load[i] <= load[i] + LOAD_W'(1);
      end else if (dec_en && (inc_svc == SVC_W'(i)) && (load[i] != '0)) begin
        load[i] <= load[i] - LOAD_W'(1);
      end
    end
  end

`include "sticky_least_loaded_router_top_defines.svh"

  `SLR_ASSERT_SAME(a_done_idle, clk, rst, done, state == S_IDLE, "result shown while busy")
  `SLR_ASSERT_SAME(a_done_src, clk, rst, done, $past(accept, 2), "result without a command")
  `SLR_ASSERT_NEXT(a_accept_done, clk, rst, accept, !done && state == S_LOOKUP, "lookup skipped")
  `SLR_ASSERT_SAME(a_unbound_zero, clk, rst, done && rsp.status == ST_UNBOUND,
                   rsp.target_service == '0, "unbound result with a service")

endmodule

FILE: test/sticky_least_loaded_router_top_tb.sv
// Self-checking testbench for the sticky least-loaded router top level.
// Depends on slr_pkg and sticky_least_loaded_router_top; a scoreboard class predicts
// every reply beat from its own copy of the route table and service loads.
module sticky_least_loaded_router_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slr_pkg::*;

  localparam int unsigned ROUTE_SLOTS = 1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_BEATS = 1650;

  class route_scoreboard;
    bit                bound[ROUTE_SLOTS];
    logic [SVC_W-1:0]  bound_svc[ROUTE_SLOTS];
    logic [LOAD_W-1:0] live_count[NUM_SVC];
    slr_rsp_t          pending_replies[$];
    int unsigned       mismatches;

    function new();
      foreach (bound[i]) begin
        bound[i] = 1'b0;
        bound_svc[i] = '0;
      end
      foreach (live_count[i]) live_count[i] = '0;
      mismatches = 0;
    endfunction

    function logic [SVC_W-1:0] least_loaded_service();
      logic [SVC_W-1:0] low_pair;
      logic [SVC_W-1:0] high_pair;
      low_pair = (live_count[0] < live_count[1]) ? 2'd0 : 2'd1;
      high_pair = (live_count[2] < live_count[3]) ? 2'd2 : 2'd3;
      return (live_count[low_pair] < live_count[high_pair]) ? low_pair : high_pair;
    endfunction

    function void note_command(slr_req_t beat);
      slr_rsp_t         reply;
      logic [SVC_W-1:0] pick;
      int unsigned      id;
      id = beat.conn_id;
      reply.target_service = '0;
      reply.status = ST_UNBOUND;
      if (id < ROUTE_SLOTS) begin
        case (beat.cmd)
          CMD_CONNECT: begin
            if (bound[id]) begin
              reply.target_service = bound_svc[id];
              reply.status = ST_DUP;
            end else begin
              pick = least_loaded_service();
              bound[id] = 1'b1;
              bound_svc[id] = pick;
              if (live_count[pick] != LOAD_MAX) live_count[pick]++;
              reply.target_service = pick;
              reply.status = ST_OK;
            end
          end
          CMD_DATA: begin
            if (bound[id]) begin
              reply.target_service = bound_svc[id];
              reply.status = ST_OK;
            end
          end
          CMD_CLOSE: begin
            if (bound[id]) begin
              reply.target_service = bound_svc[id];
              reply.status = ST_OK;
              if (live_count[bound_svc[id]] != '0) live_count[bound_svc[id]]--;
              bound[id] = 1'b0;
              bound_svc[id] = '0;
            end
          end
          default: ;
        endcase
      end
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(slr_rsp_t got);
      slr_rsp_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply beat: service %0d status %0d",
                   got.target_service, got.status);
        return;
      end
      want = pending_replies.pop_front();
      if (got.target_service !== want.target_service || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: expected service %0d status %0d, got service %0d status %0d",
                   want.target_service, want.status, got.target_service, got.status);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  slr_req_t req;
  logic     done;
  slr_rsp_t rsp;

  route_scoreboard sb;
  bit              taken;
  int unsigned     idle_cycles;
  int unsigned     burst_left;
  int              live_ids[$];

  sticky_least_loaded_router_top u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      taken = 1'b0;
      idle_cycles = 0;
    end else begin
      taken = start && !busy;
      if (done) sb.check_reply(rsp);
      if (taken) sb.note_command(req);
      if (taken || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** sticky_least_loaded_router_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic issue(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id);
    slr_req_t beat;
    beat.cmd = c;
    beat.conn_id = id;
    start <= 1'b1;
    req <= beat;
    do @(negedge clk); while (!taken);
  endtask

  // Bursts of back-to-back beats separated by random gaps; some bursts follow
  // the previous one with no gap at all.
  task automatic send(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    issue(c, id);
  endtask

  task automatic run_directed();
    send(CMD_CONNECT, 10'd0);
    send(CMD_CONNECT, 10'd1023);
    send(CMD_CONNECT, 10'd0);
    send(CMD_DATA, 10'd0);
    send(CMD_DATA, 10'd1023);
    send(CMD_DATA, 10'd5);
    send(CMD_CONNECT, 10'd10);
    send(CMD_CONNECT, 10'd11);
    send(CMD_CONNECT, 10'd12);
    send(CMD_CONNECT, 10'd13);
    send(CMD_CLOSE, 10'd11);
    send(CMD_CONNECT, 10'd14);
    send(CMD_CLOSE, 10'd0);
    send(CMD_CLOSE, 10'd0);
    send(CMD_DATA, 10'd0);
    send(CMD_CLOSE, 10'd1023);
    send(CMD_UNUSED, 10'd1023);
    send(CMD_UNUSED, 10'd0);
    send(CMD_CONNECT, 10'h2AA);
    send(CMD_CONNECT, 10'h155);
    send(CMD_CLOSE, 10'h2AA);
    send(CMD_CLOSE, 10'h155);
  endtask

  task automatic run_random();
    int unsigned span;
    int unsigned base;
    int unsigned roll;
    int unsigned pick;
    logic [ID_W-1:0] id;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: span = 16;
          1: span = 128;
          default: span = ROUTE_SLOTS;
        endcase
        base = $urandom_range(0, ROUTE_SLOTS - 1);
      end
      id = ID_W'(base + $urandom_range(0, span - 1));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send(CMD_UNUSED, ID_W'($urandom));
      end else if (roll < 48) begin
        send(CMD_CONNECT, id);
        live_ids.push_back(id);
      end else if (roll < 72) begin
        if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
          id = ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        send(CMD_DATA, id);
      end else begin
        if (live_ids.size() != 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, live_ids.size() - 1);
          id = ID_W'(live_ids[pick]);
          live_ids.delete(pick);
        end
        send(CMD_CLOSE, id);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("** sticky_least_loaded_router_top: PASSED **");
    end else begin
      $display("** sticky_least_loaded_router_top: FAILED **");
    end
    $finish;
  end

endmodule
